[src/kcv_pkg.sv]
// Package: fixed-point constants, opcodes and a saturation helper function for the tracker.
package kcv_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned RegW = 31;
	localparam int unsigned FracBitsDefault = 16;
	localparam int unsigned NumRegs = 2;
	localparam int unsigned RegIdxW = 1;

	localparam logic [RegIdxW-1:0] REG_PROCESS_NOISE = 1'd0;
	localparam logic [RegIdxW-1:0] REG_MEAS_NOISE = 1'd1;

	// operand register file slot indexes (32 entries of 32 bits)
	localparam int unsigned SlotW = 5;

	typedef logic [SlotW-1:0] slot_t;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_NOP = 3'd4
	} op_t;

	// one micro-instruction of the update program
	typedef struct packed {
		op_t   op;
		slot_t dst;
		slot_t src_a;
		slot_t src_b;
	} uop_t;

	// saturate a 64-bit signed value into 32 bits
	function automatic logic signed [WordW-1:0] sat32(input logic signed [63:0] v);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		begin
			hi = 64'sd2147483647;
			lo = -64'sd2147483648;
			if (v > hi)
				sat32 = 32'sh7fffffff;
			else if (v < lo)
				sat32 = 32'sh80000000;
			else
				sat32 = v[WordW-1:0];
		end
	endfunction

endpackage

[src/kcv_core.sv]
// Datapath: operand file, shared ALU with multiplier and serial divider, program sequencer.
module kcv_core #(
	parameter int unsigned FRAC_BITS = kcv_pkg::FracBitsDefault
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       seed,
	input  logic signed [31:0]         zx,
	input  logic signed [31:0]         zy,
	input  logic [30:0]                q_val,
	input  logic [30:0]                r_val,
	output logic                       done,
	output logic signed [31:0]         px,
	output logic signed [31:0]         py
);
	import kcv_pkg::*;

	// slot map
	localparam slot_t S_PX = 5'd0, S_PY = 5'd1, S_VX = 5'd2, S_VY = 5'd3;
	localparam slot_t S_P0 = 5'd4;      // P occupies slots 4..19, row-major
	localparam slot_t S_ZX = 5'd20, S_ZY = 5'd21, S_Q = 5'd22, S_R = 5'd23;
	localparam slot_t S_ZERO = 5'd24;
	localparam slot_t T0 = 5'd25, T1 = 5'd26, T2 = 5'd27, T3 = 5'd28;
	localparam slot_t T4 = 5'd29, T5 = 5'd30, T6 = 5'd31;

	localparam int unsigned ProgLen = 256;
	localparam int unsigned PcW = 8;
	localparam int unsigned DivW = 64;
	localparam int unsigned DivCntW = 7;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_RUN  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	// Program held in a scratch program store (more than 32 entries -> memory),
	// and a small extra scratch for the update. We keep all live values in slots
	// by using the register file as follows during update:
	// pp overwrites P in place, m computed in place too. xp overwrites state.
	// Extra temporaries needed: y0,y1, sa,sd, det, i00..i11, k[8].
	// Those exceed free slots, so a second bank of 32 words is used.
	localparam slot_t B_Y0 = 5'd0, B_Y1 = 5'd1, B_SA = 5'd2, B_SD = 5'd3, B_DET = 5'd4;
	localparam slot_t B_I00 = 5'd5, B_I01 = 5'd6, B_I10 = 5'd7, B_I11 = 5'd8;
	localparam slot_t B_K0 = 5'd9; // k[0..7] at 9..16

	// address space: bit 5 selects bank B (6-bit addresses)
	typedef logic [5:0] addr_t;

	typedef struct packed {
		op_t   op;
		addr_t dst;
		addr_t a;
		addr_t b;
		logic  skip_zero; // skip this op when det is zero (writes 0 instead)
	} ins_t;

	function automatic addr_t A(input slot_t s);
		A = {1'b0, s};
	endfunction
	function automatic addr_t B(input slot_t s);
		B = {1'b1, s};
	endfunction
	function automatic addr_t PA(input int i, input int j);
		PA = A(5'(int'(S_P0) + i * 4 + j));
	endfunction
	function automatic addr_t KA(input int i, input int c);
		KA = B(5'(int'(B_K0) + i * 2 + c));
	endfunction

	function automatic ins_t mk(input op_t o, input addr_t d, input addr_t a, input addr_t b,
	                            input logic z);
		ins_t r;
		begin
			r.op = o; r.dst = d; r.a = a; r.b = b; r.skip_zero = z;
			mk = r;
		end
	endfunction

	// build program as a constant table (elaboration-time)
	function automatic ins_t prog_at(input logic [PcW-1:0] pc);
		ins_t p [ProgLen];
		int n;
		int i;
		int j;
		begin
			for (i = 0; i < ProgLen; i++) p[i] = mk(OP_NOP, A(S_ZERO), A(S_ZERO), A(S_ZERO), 1'b0);
			n = 0;
			// predict state; y before overwrite uses xp
			p[n] = mk(OP_ADD, A(S_PX), A(S_PX), A(S_VX), 1'b0); n++;
			p[n] = mk(OP_ADD, A(S_PY), A(S_PY), A(S_VY), 1'b0); n++;
			// m = A P (rows 0,1)
			for (j = 0; j < 4; j++) begin
				p[n] = mk(OP_ADD, PA(0, j), PA(0, j), PA(2, j), 1'b0); n++;
				p[n] = mk(OP_ADD, PA(1, j), PA(1, j), PA(3, j), 1'b0); n++;
			end
			// pp = m A^T + Q
			for (i = 0; i < 4; i++) begin
				p[n] = mk(OP_ADD, PA(i, 0), PA(i, 0), PA(i, 2), 1'b0); n++;
				p[n] = mk(OP_ADD, PA(i, 1), PA(i, 1), PA(i, 3), 1'b0); n++;
			end
			for (i = 0; i < 4; i++) begin
				p[n] = mk(OP_ADD, PA(i, i), PA(i, i), A(S_Q), 1'b0); n++;
			end
			p[n] = mk(OP_SUB, B(B_Y0), A(S_ZX), A(S_PX), 1'b0); n++;
			p[n] = mk(OP_SUB, B(B_Y1), A(S_ZY), A(S_PY), 1'b0); n++;
			p[n] = mk(OP_ADD, B(B_SA), PA(0, 0), A(S_R), 1'b0); n++;
			p[n] = mk(OP_ADD, B(B_SD), PA(1, 1), A(S_R), 1'b0); n++;
			p[n] = mk(OP_MUL, A(T0), B(B_SA), B(B_SD), 1'b0); n++;
			p[n] = mk(OP_MUL, A(T1), PA(0, 1), PA(1, 0), 1'b0); n++;
			p[n] = mk(OP_SUB, B(B_DET), A(T0), A(T1), 1'b0); n++;
			p[n] = mk(OP_SUB, A(T2), A(S_ZERO), PA(0, 1), 1'b0); n++;
			p[n] = mk(OP_SUB, A(T3), A(S_ZERO), PA(1, 0), 1'b0); n++;
			p[n] = mk(OP_DIV, B(B_I00), B(B_SD), B(B_DET), 1'b1); n++;
			p[n] = mk(OP_DIV, B(B_I01), A(T2), B(B_DET), 1'b1); n++;
			p[n] = mk(OP_DIV, B(B_I10), A(T3), B(B_DET), 1'b1); n++;
			p[n] = mk(OP_DIV, B(B_I11), B(B_SA), B(B_DET), 1'b1); n++;
			// gain
			for (i = 0; i < 4; i++) begin
				p[n] = mk(OP_MUL, A(T0), PA(i, 0), B(B_I00), 1'b0); n++;
				p[n] = mk(OP_MUL, A(T1), PA(i, 1), B(B_I10), 1'b0); n++;
				p[n] = mk(OP_ADD, KA(i, 0), A(T0), A(T1), 1'b0); n++;
				p[n] = mk(OP_MUL, A(T0), PA(i, 0), B(B_I01), 1'b0); n++;
				p[n] = mk(OP_MUL, A(T1), PA(i, 1), B(B_I11), 1'b0); n++;
				p[n] = mk(OP_ADD, KA(i, 1), A(T0), A(T1), 1'b0); n++;
			end
			// state update
			for (i = 0; i < 4; i++) begin
				p[n] = mk(OP_MUL, A(T0), KA(i, 0), B(B_Y0), 1'b0); n++;
				p[n] = mk(OP_MUL, A(T1), KA(i, 1), B(B_Y1), 1'b0); n++;
				p[n] = mk(OP_ADD, A(T0), A(T0), A(T1), 1'b0); n++;
				p[n] = mk(OP_ADD, A(5'(int'(S_PX) + i)), A(5'(int'(S_PX) + i)), A(T0), 1'b0); n++;
			end
			// covariance update: rows 0,1 are read by every row, so compute rows
			// 2,3 first? Row i uses pp[0][j], pp[1][j] for all i; keep copies of
			// rows 0 and 1 in bank B (slots 17..24).
			for (j = 0; j < 4; j++) begin
				p[n] = mk(OP_ADD, B(5'(17 + j)), PA(0, j), A(S_ZERO), 1'b0); n++;
				p[n] = mk(OP_ADD, B(5'(21 + j)), PA(1, j), A(S_ZERO), 1'b0); n++;
			end
			for (i = 0; i < 4; i++)
				for (j = 0; j < 4; j++) begin
					p[n] = mk(OP_MUL, A(T0), KA(i, 0), B(5'(17 + j)), 1'b0); n++;
					p[n] = mk(OP_MUL, A(T1), KA(i, 1), B(5'(21 + j)), 1'b0); n++;
					p[n] = mk(OP_ADD, A(T0), A(T0), A(T1), 1'b0); n++;
					p[n] = mk(OP_SUB, PA(i, j), PA(i, j), A(T0), 1'b0); n++;
				end
			prog_at = p[pc];
		end
	endfunction

	// address of the last real instruction above (147 instructions)
	localparam logic [PcW-1:0] LastPc = 8'd146;

	state_t state_q;
	logic [PcW-1:0] pc_q;
	logic signed [31:0] rf_a [32];
	logic signed [31:0] rf_b [32];
	ins_t ins;
	logic signed [31:0] opa;
	logic signed [31:0] opb;
	logic signed [31:0] res;
	logic signed [63:0] prod;
	logic signed [63:0] wide;
	logic det_zero;
	logic wr_en;

	// serial divider state
	logic [DivW-1:0] rem_q;
	logic [DivW-1:0] quo_q;
	logic [DivW-1:0] den_q;
	logic [DivCntW-1:0] dcnt_q;
	logic neg_q;
	logic [DivW:0] trial;
	logic [DivW-1:0] rnd;
	logic signed [DivW:0] sq;

	assign ins = prog_at(pc_q);
	assign opa = ins.a[5] ? rf_b[ins.a[4:0]] : rf_a[ins.a[4:0]];
	assign opb = ins.b[5] ? rf_b[ins.b[4:0]] : rf_a[ins.b[4:0]];
	assign det_zero = (rf_b[B_DET] == '0);
	assign prod = 64'(opa) * 64'(opb) + (64'sd1 <<< (FRAC_BITS - 1));
	assign trial = {1'b0, rem_q[DivW-2:0], quo_q[DivW-1]} - {1'b0, den_q};

	// round to nearest: quotient has one extra fraction bit (ties away)
	assign rnd = (quo_q >> 1) + {{(DivW-1){1'b0}}, quo_q[0]};
	assign sq = neg_q ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});

	always_comb begin
		wide = '0;
		case (ins.op)
			OP_ADD: wide = 64'(opa) + 64'(opb);
			OP_SUB: wide = 64'(opa) - 64'(opb);
			OP_MUL: wide = prod >>> FRAC_BITS;
			default: wide = 64'(sq);
		endcase
		res = sat32(wide);
	end

	assign wr_en = (state_q == ST_RUN && ins.op != OP_DIV && ins.op != OP_NOP)
		|| (state_q == ST_DIV && dcnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q <= '0;
			dcnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					pc_q <= '0;
					if (start) state_q <= seed ? ST_DONE : ST_RUN;
				end
				ST_RUN: begin
					if (ins.op == OP_DIV && !(ins.skip_zero && det_zero)) begin
						state_q <= ST_DIV;
						dcnt_q <= DivCntW'(DivW);
					end else if (pc_q == LastPc) begin
						state_q <= ST_DONE;
					end else begin
						pc_q <= pc_q + 1'b1;
					end
				end
				ST_DIV: begin
					if (dcnt_q == '0) begin
						state_q <= ST_RUN;
						pc_q <= pc_q + 1'b1;
					end else begin
						dcnt_q <= dcnt_q - 1'b1;
					end
				end
				ST_DONE: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// restoring divider: (|n| << (F+1)) / |d|, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (state_q == ST_RUN && ins.op == OP_DIV) begin
			rem_q <= '0;
			quo_q <= DivW'(opa[31] ? -64'(opa) : 64'(opa)) << (FRAC_BITS + 1);
			den_q <= DivW'(opb[31] ? -64'(opb) : 64'(opb));
			neg_q <= opa[31] ^ opb[31];
		end else if (state_q == ST_DIV && dcnt_q != '0) begin
			if (!trial[DivW]) begin
				rem_q <= trial[DivW-1:0];
				quo_q <= {quo_q[DivW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DivW-2:0], quo_q[DivW-1]};
				quo_q <= {quo_q[DivW-2:0], 1'b0};
			end
		end
	end

	// register file: reset values for state and covariance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 32; i++) begin
				rf_a[i] <= '0;
				rf_b[i] <= '0;
			end
			for (int i = 0; i < 4; i++)
				rf_a[int'(S_P0) + i * 5] <= 32'sd1 <<< FRAC_BITS;
		end else begin
			rf_a[S_Q] <= $signed({1'b0, q_val});
			rf_a[S_R] <= $signed({1'b0, r_val});
			rf_a[S_ZERO] <= '0;
			if (state_q == ST_IDLE && start) begin
				rf_a[S_ZX] <= zx;
				rf_a[S_ZY] <= zy;
				if (seed) begin
					rf_a[S_PX] <= zx;
					rf_a[S_PY] <= zy;
					rf_a[S_VX] <= '0;
					rf_a[S_VY] <= '0;
				end
			end else if (state_q == ST_RUN && ins.op == OP_DIV && ins.skip_zero && det_zero) begin
				rf_b[ins.dst[4:0]] <= '0;
			end else if (wr_en) begin
				if (ins.dst[5])
					rf_b[ins.dst[4:0]] <= res;
				else
					rf_a[ins.dst[4:0]] <= res;
			end
		end
	end

	assign done = (state_q == ST_DONE);
	assign px = rf_a[S_PX];
	assign py = rf_a[S_PY];

endmodule

[src/kalman_cv_2d_tracker.sv]
// Top level: 2D constant-velocity Kalman tracker with request channels and register port.
// Each request carries one measured point and returns one filtered position.
// The first request after reset seeds the track and is echoed back through the
// core's DONE state and the output register; every later request runs a fixed
// micro-program of 147 add, subtract, multiply and divide steps on one shared
// ALU, and its four serial divisions hold the sequencer until each quotient is
// done. The divisions are skipped when the innovation covariance is singular.
// The shared ALU and the one-bit-a-cycle divider set how long a request takes.
// in_stall is high while a request is at work or a result waits on the output
// register, so the next request is accepted on the cycle after the result is
// taken.
module kalman_cv_2d_tracker #(
	parameter int unsigned FRAC_BITS = kcv_pkg::FracBitsDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] meas_x,
	input  logic signed [31:0] meas_y,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] est_x,
	output logic signed [31:0] est_y,
	input  logic               cfg_we,
	input  logic [kcv_pkg::RegIdxW-1:0] cfg_index,
	input  logic [kcv_pkg::RegW-1:0]    cfg_data
);
	import kcv_pkg::*;

	logic [RegW-1:0] q_q;
	logic [RegW-1:0] r_q;
	logic seeded_q;
	logic busy_q;
	logic start;
	logic done;
	logic signed [31:0] px;
	logic signed [31:0] py;

	// hold the noise registers; defaults round(0.1 * 2^F) and round(0.001 * 2^F)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q <= RegW'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
			r_q <= RegW'(((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PROCESS_NOISE: q_q <= cfg_data;
				REG_MEAS_NOISE: r_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_stall = busy_q || out_valid;
	assign start = in_valid && !in_stall;

	kcv_core #(.FRAC_BITS(FRAC_BITS)) u_core (
		.clk(clk), .arst_n(arst_n), .start(start), .seed(!seeded_q),
		.zx(meas_x), .zy(meas_y), .q_val(q_q), .r_val(r_q),
		.done(done), .px(px), .py(py)
	);

	// busy from accept until the result lands in the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			seeded_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				seeded_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end
			if (done)
				out_valid <= 1'b1;
			else if (!out_stall)
				out_valid <= 1'b0;
		end
	end

	// capture the result when the core finishes
	always_ff @(posedge clk) begin
		if (done) begin
			est_x <= px;
			est_y <= py;
		end
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !start) else $error("request accepted while busy");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy_q) else $error("core done without request");
	a_result_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> out_valid && !busy_q) else $error("result not presented");

endmodule

[sim/tb_top.sv]
// Self-checking testbench for the 2D constant-velocity Kalman tracker.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import kcv_pkg::*;

	localparam int FRAC = FracBitsDefault;
	localparam int SETTLE = 600;            // about one full request plus margin
	localparam longint CYCLE_LIMIT = 3000000;
	localparam int HOLD_LEN = 3000;

	typedef struct {
		int x;
		int y;
	} point_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [31:0] meas_x = '0;
	logic signed [31:0] meas_y = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] est_x;
	logic signed [31:0] est_y;
	logic cfg_we = 1'b0;
	logic [RegIdxW-1:0] cfg_index = '0;
	logic [RegW-1:0] cfg_data = '0;

	kalman_cv_2d_tracker dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .meas_x(meas_x), .meas_y(meas_y),
		.out_valid(out_valid), .out_stall(out_stall), .est_x(est_x), .est_y(est_y),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// Shadow of the filter: state, covariance and noise registers.
	int trk[4];
	int cov[16];
	bit trk_seeded;
	int q_diag;
	int r_diag;

	point_t est_q[$];
	int fail_count = 0;
	longint cycles = 0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;

	// ---------------- fixed-point arithmetic ----------------
	function automatic int clip(longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return int'(v);
	endfunction

	function automatic int fx_add(int a, int b);
		return clip(longint'(a) + longint'(b));
	endfunction

	function automatic int fx_sub(int a, int b);
		return clip(longint'(a) - longint'(b));
	endfunction

	// round half up, then floor shift (arithmetic shift floors)
	function automatic int fx_mul(int a, int b);
		longint p;
		p = longint'(a) * longint'(b) + (64'sd1 <<< (FRAC - 1));
		return clip(p >>> FRAC);
	endfunction

	// round to nearest, ties away from zero; zero divisor gives zero
	function automatic int fx_div(int n, int d);
		longint num, an, ad, q;
		num = longint'(n) <<< FRAC;
		an = (num < 0) ? -num : num;
		ad = (d < 0) ? -longint'(d) : longint'(d);
		if (ad == 0) return 0;
		q = (an + ad / 2) / ad;
		if ((num < 0) != (d < 0)) q = -q;
		return clip(q);
	endfunction

	function automatic void reset_tracker();
		for (int i = 0; i < 4; i++) trk[i] = 0;
		for (int i = 0; i < 16; i++) cov[i] = (i % 5 == 0) ? (1 << FRAC) : 0;
		trk_seeded = 0;
		q_diag = ((1 << FRAC) + 5) / 10;
		r_diag = ((1 << FRAC) + 500) / 1000;
	endfunction

	// Advance the shadow filter by one measurement and return the estimate.
	function automatic point_t track_point(int zx, int zy);
		int xp[4], m[16], pp[16], k[8], yv[2];
		int sa, sb, sc, sd, det, i00, i01, i10, i11, t;
		point_t r;
		if (!trk_seeded) begin
			trk[0] = zx; trk[1] = zy; trk[2] = 0; trk[3] = 0;
			trk_seeded = 1;
			r.x = zx; r.y = zy;
			return r;
		end
		xp[0] = fx_add(trk[0], trk[2]);
		xp[1] = fx_add(trk[1], trk[3]);
		xp[2] = trk[2];
		xp[3] = trk[3];
		for (int j = 0; j < 4; j++) begin
			m[j] = fx_add(cov[j], cov[8 + j]);
			m[4 + j] = fx_add(cov[4 + j], cov[12 + j]);
			m[8 + j] = cov[8 + j];
			m[12 + j] = cov[12 + j];
		end
		for (int i = 0; i < 4; i++) begin
			pp[i*4] = fx_add(m[i*4], m[i*4 + 2]);
			pp[i*4 + 1] = fx_add(m[i*4 + 1], m[i*4 + 3]);
			pp[i*4 + 2] = m[i*4 + 2];
			pp[i*4 + 3] = m[i*4 + 3];
			pp[i*4 + i] = fx_add(pp[i*4 + i], q_diag);
		end
		yv[0] = fx_sub(zx, xp[0]);
		yv[1] = fx_sub(zy, xp[1]);
		sa = fx_add(pp[0], r_diag);
		sb = pp[1];
		sc = pp[4];
		sd = fx_add(pp[5], r_diag);
		det = fx_sub(fx_mul(sa, sd), fx_mul(sb, sc));
		if (det == 0) begin
			i00 = 0; i01 = 0; i10 = 0; i11 = 0;
		end else begin
			i00 = fx_div(sd, det);
			i01 = fx_div(fx_sub(0, sb), det);
			i10 = fx_div(fx_sub(0, sc), det);
			i11 = fx_div(sa, det);
		end
		for (int i = 0; i < 4; i++) begin
			k[i*2] = fx_add(fx_mul(pp[i*4], i00), fx_mul(pp[i*4 + 1], i10));
			k[i*2 + 1] = fx_add(fx_mul(pp[i*4], i01), fx_mul(pp[i*4 + 1], i11));
		end
		for (int i = 0; i < 4; i++)
			trk[i] = fx_add(xp[i], fx_add(fx_mul(k[i*2], yv[0]), fx_mul(k[i*2 + 1], yv[1])));
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++) begin
				t = fx_add(fx_mul(k[i*2], pp[j]), fx_mul(k[i*2 + 1], pp[4 + j]));
				cov[i*4 + j] = fx_sub(pp[i*4 + j], t);
			end
		r.x = trk[0]; r.y = trk[1];
		return r;
	endfunction

	// ---------------- drivers ----------------
	// Send one request; entered and left at a rising edge, valid left high.
	task automatic send_point(int x, int y);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		end
		in_valid <= 1'b1;
		meas_x <= x;
		meas_y <= y;
		// inputs are stable at the falling edge: accept happens at the next rise
		@(negedge clk);
		while (in_stall) @(negedge clk);
		est_q.push_back(track_point(x, y));
		@(posedge clk);
	endtask

	task automatic end_burst();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Wait until the block is idle, then write one register.
	task automatic write_reg(logic [RegIdxW-1:0] idx, logic [RegW-1:0] val);
		wait (est_q.size() == 0);
		repeat (SETTLE) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_PROCESS_NOISE) q_diag = int'({1'b0, val});
		else r_diag = int'({1'b0, val});
	endtask

	// Receiver: random stall, plus a long hold-off counted here on request.
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_LEN;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Result check: outputs are stable at the falling edge before acceptance.
	always @(negedge clk) begin
		point_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (est_q.size() == 0) begin
				$error("unexpected result est_x=%0d est_y=%0d", est_x, est_y);
				fail_count++;
			end else begin
				e = est_q.pop_front();
				if (est_x !== e.x) begin
					$error("est_x: expected %0d, actual %0d", e.x, est_x);
					fail_count++;
				end
				if (est_y !== e.y) begin
					$error("est_y: expected %0d, actual %0d", e.y, est_y);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// ---------------- stimulus ----------------
	int trk_px, trk_py, trk_vx, trk_vy, trk_left;

	// Mostly smooth tracks with small jitter; some wild full-range points.
	task automatic send_random_point();
		int x, y;
		if ($urandom_range(99) < 15) begin
			x = $urandom;
			y = $urandom;
		end else begin
			if (trk_left == 0) begin
				trk_px = $signed($urandom) >>> $urandom_range(3, 12);
				trk_py = $signed($urandom) >>> $urandom_range(3, 12);
				trk_vx = $signed($urandom) >>> $urandom_range(8, 20);
				trk_vy = $signed($urandom) >>> $urandom_range(8, 20);
				trk_left = $urandom_range(5, 40);
			end
			trk_left--;
			trk_px = fx_add(trk_px, trk_vx);
			trk_py = fx_add(trk_py, trk_vy);
			x = fx_add(trk_px, $signed($urandom) >>> $urandom_range(12, 24));
			y = fx_add(trk_py, $signed($urandom) >>> $urandom_range(12, 24));
		end
		send_point(x, y);
	endtask

	task automatic test_seed_and_extremes();
		send_point(32'sh12345678, -32'sh0abcdef0);   // seeds the track, echoed back
		send_point(32'sh12345678, -32'sh0abcdef0);
		send_point(32'sh7fffffff, 32'sh7fffffff);
		send_point(32'sh80000000, 32'sh80000000);
		send_point(32'sh7fffffff, 32'sh80000000);
		send_point(32'sh80000000, 32'sh7fffffff);
		send_point(0, 0);
		send_point(-1, 1);
		send_point(32'sh00010000, -32'sh00010000);
		end_burst();
	endtask

	task automatic test_noise_settings();
		// zero noise on both diagonals drives the singular-innovation path
		write_reg(REG_PROCESS_NOISE, 31'd0);
		write_reg(REG_MEAS_NOISE, 31'd0);
		for (int i = 0; i < 4; i++) send_point(i * 32'sh00020000, -i * 32'sh00010000);
		end_burst();
		write_reg(REG_PROCESS_NOISE, 31'h7fffffff);
		write_reg(REG_MEAS_NOISE, 31'h7fffffff);
		for (int i = 0; i < 4; i++) send_point($urandom, $urandom);
		end_burst();
		write_reg(REG_PROCESS_NOISE, 31'h7fffffff);
		write_reg(REG_MEAS_NOISE, 31'd1);
		for (int i = 0; i < 3; i++) send_point(32'sh7fff0000, 32'sh80010000);
		end_burst();
		write_reg(REG_PROCESS_NOISE, 31'd6554);
		write_reg(REG_MEAS_NOISE, 31'd66);
	endtask

	task automatic test_random_phase(int snd_pct, int rcv_pct, int n);
		logic [RegW-1:0] qv, rv;
		qv = RegW'(($urandom_range(3) == 0) ? $urandom : $urandom_range(1 << 18));
		rv = RegW'(($urandom_range(3) == 0) ? $urandom : $urandom_range(1, 1 << 16));
		write_reg(REG_PROCESS_NOISE, qv);
		write_reg(REG_MEAS_NOISE, rv);
		send_idle_pct = snd_pct;
		recv_stall_pct = rcv_pct;
		for (int i = 0; i < n; i++) begin
			send_random_point();
			// hold some stretches with no idling at all
			if (i % 60 == 30) begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end else if (i % 60 == 45) begin
				send_idle_pct = snd_pct;
				recv_stall_pct = rcv_pct;
			end
		end
		end_burst();
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req++;
		for (int i = 0; i < 12; i++) send_random_point();
		end_burst();
	endtask

	initial begin
		reset_tracker();
		trk_left = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_seed_and_extremes();
		test_noise_settings();
		test_random_phase(22, 56, 280);
		test_random_phase(56, 22, 280);
		test_random_phase(0, 0, 270);
		test_backpressure();

		wait (est_q.size() == 0);
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0 && est_q.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
